// ===== sv/ttdm_pkg.sv =====
// shared types and constants for the tick timer with deadline compare
// used by ttdm_ctrl, ttdm_dp and tick_timer_delay_and_ms; no dependencies
package ttdm_pkg;

    // widths of the words and registers
    localparam int CNT_W    = 64;
    localparam int WORD_W   = 32;
    localparam int RATE_W   = 10;
    localparam int PROD_W   = WORD_W + RATE_W;
    localparam int DIVR_W   = 20;
    localparam int STEP_W   = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // constants of the conversion
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(100);
    localparam logic [DIVR_W-1:0] MS_PER_US  = DIVR_W'(1000);
    localparam logic [WORD_W-1:0] SAT_TICKS  = {WORD_W{1'b1}};
    localparam logic [STEP_W-1:0] DIV_LAST   = {STEP_W{1'b1}};

    // register word index
    localparam logic REG_TPU = 1'b0;

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_DELAY = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ARM,
        ST_DIV,
        ST_FIN
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic arm;
        logic div_step;
        logic finish;
    } cmd_t;

endpackage

// ===== sv/ttdm_dp.sv =====
// datapath: tick counter, deadline, saturating multiplier and restoring divider
// depends on ttdm_pkg; driven by commands from ttdm_ctrl
module ttdm_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ttdm_pkg::cmd_t                  cmd,
    input  logic [ttdm_pkg::RATE_W-1:0]     rate,
    input  logic [1:0]                      req_type,
    input  logic [ttdm_pkg::WORD_W-1:0]     delay_usec,
    input  logic [ttdm_pkg::WORD_W-1:0]     base_ms,
    output logic [ttdm_pkg::WORD_W-1:0]     elapsed_ms,
    output logic                            delay_done,
    output logic                            delay_overflow
);

    logic [ttdm_pkg::CNT_W-1:0]   count_reg;
    logic [ttdm_pkg::CNT_W-1:0]   count_next;
    logic [ttdm_pkg::CNT_W-1:0]   deadline_reg;
    logic [ttdm_pkg::CNT_W-1:0]   deadline_next;
    ttdm_pkg::req_t               req_reg;
    logic [ttdm_pkg::WORD_W-1:0]  usec_reg;
    logic [ttdm_pkg::WORD_W-1:0]  base_reg;
    logic [ttdm_pkg::RATE_W-1:0]  rate_eff;
    logic [ttdm_pkg::DIVR_W-1:0]  divisor_reg;
    logic [ttdm_pkg::PROD_W-1:0]  prod_reg;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic [ttdm_pkg::WORD_W-1:0]  ticks;
    logic [ttdm_pkg::DIVR_W-1:0]  rem_reg;
    logic [ttdm_pkg::CNT_W-1:0]   quo_reg;
    logic [ttdm_pkg::DIVR_W:0]    trial;
    logic [ttdm_pkg::DIVR_W:0]    trial_diff;
    logic                         trial_ge;
    logic [ttdm_pkg::WORD_W-1:0]  elapsed_reg;
    logic                         done_reg;
    logic                         ovf_out_reg;

    // a rate of zero counts as one
    assign rate_eff = (rate == '0) ? ttdm_pkg::RATE_W'(1) : rate;

    // saturated tick count from the registered product
    assign ovf_next = |prod_reg[ttdm_pkg::PROD_W-1:ttdm_pkg::WORD_W];
    assign ticks    = ovf_next ? ttdm_pkg::SAT_TICKS : prod_reg[ttdm_pkg::WORD_W-1:0];

    // counter and deadline updates
    always_comb
    begin
        count_next    = count_reg;
        deadline_next = deadline_reg;
        if (cmd.load && (ttdm_pkg::req_t'(req_type) == ttdm_pkg::REQ_TICK))
        begin
            count_next = count_reg + ttdm_pkg::CNT_W'(1);
        end
        if (cmd.arm)
        begin
            deadline_next = count_reg + {{(ttdm_pkg::CNT_W-ttdm_pkg::WORD_W){1'b0}}, ticks};
        end
    end

    // one restoring division step per cycle
    assign trial      = {rem_reg, quo_reg[ttdm_pkg::CNT_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            deadline_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            deadline_reg <= deadline_next;
        end
    end

    // working and result words
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= ttdm_pkg::req_t'(req_type);
            usec_reg    <= delay_usec;
            base_reg    <= base_ms;
            divisor_reg <= ttdm_pkg::DIVR_W'(rate_eff) * ttdm_pkg::MS_PER_US;
            quo_reg     <= count_reg;
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[ttdm_pkg::DIVR_W-1:0]
                                : trial[ttdm_pkg::DIVR_W-1:0];
            quo_reg <= {quo_reg[ttdm_pkg::CNT_W-2:0], trial_ge};
        end
        if (cmd.mul)
        begin
            prod_reg <= ttdm_pkg::PROD_W'(usec_reg) * ttdm_pkg::PROD_W'(rate_eff);
        end
        if (cmd.arm)
        begin
            ovf_reg <= ovf_next;
        end
        if (cmd.finish)
        begin
            elapsed_reg <= (req_reg == ttdm_pkg::REQ_READ)
                         ? quo_reg[ttdm_pkg::WORD_W-1:0] - base_reg : '0;
            done_reg    <= (count_reg >= deadline_reg);
            ovf_out_reg <= (req_reg == ttdm_pkg::REQ_DELAY) ? ovf_reg : 1'b0;
        end
    end

    assign elapsed_ms     = elapsed_reg;
    assign delay_done     = done_reg;
    assign delay_overflow = ovf_out_reg;

endmodule

// ===== sv/ttdm_ctrl.sv =====
// controller: request sequencing, divider step count and output word handshake
// depends on ttdm_pkg; commands ttdm_dp
module ttdm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      req_type,
    output logic            out_valid,
    input  logic            out_ready,
    output ttdm_pkg::cmd_t  cmd
);

    ttdm_pkg::state_t               state_reg;
    ttdm_pkg::state_t               state_next;
    logic [ttdm_pkg::STEP_W-1:0]    step_reg;
    logic [ttdm_pkg::STEP_W-1:0]    step_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ttdm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (ttdm_pkg::req_t'(req_type))
                        ttdm_pkg::REQ_DELAY: state_next = ttdm_pkg::ST_MUL;
                        ttdm_pkg::REQ_READ:  state_next = ttdm_pkg::ST_DIV;
                        default:             state_next = ttdm_pkg::ST_FIN;
                    endcase
                end
            end
            ttdm_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ttdm_pkg::ST_ARM;
            end
            ttdm_pkg::ST_ARM:
            begin
                cmd.arm    = 1'b1;
                state_next = ttdm_pkg::ST_FIN;
            end
            ttdm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == ttdm_pkg::DIV_LAST)
                begin
                    state_next = ttdm_pkg::ST_FIN;
                end
            end
            ttdm_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ttdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttdm_pkg::ST_IDLE;
            end
        endcase
    end

    // divider step count and output word flag
    always_comb
    begin
        step_next = step_reg;
        if (cmd.load)
        begin
            step_next = '0;
        end
        else if (cmd.div_step)
        begin
            step_next = step_reg + ttdm_pkg::STEP_W'(1);
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttdm_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // an accepted word always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ttdm_pkg::ST_IDLE))
        else $error("accepted word did not leave idle");

    // a finished word is shown on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished word not presented");

    // the last divider step hands over to the result stage
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ttdm_pkg::ST_DIV) && (step_reg == ttdm_pkg::DIV_LAST))
        |=> (state_reg == ttdm_pkg::ST_FIN))
        else $error("divider overran its step count");

    // a read starts the divider from step zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (ttdm_pkg::req_t'(req_type) == ttdm_pkg::REQ_READ))
        |=> ((state_reg == ttdm_pkg::ST_DIV) && (step_reg == '0)))
        else $error("read did not start divider cleanly");

    // a pending word is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.finish)
        else $error("output word overwritten while stalled");
`endif

endmodule

// ===== sv/tick_timer_delay_and_ms.sv =====
// A tick or unused code goes from acceptance to the FIN state, which waits for a free
// output register; a start delay passes the multiply and arm states first, and a
// millisecond read the divider. A new word is taken once the previous one has reached
// the output register. A read runs the 64-step restoring divider, one quotient bit per cycle.
// Reset clears the counter, the deadline and all handshake state and loads the
// ticks-per-microsecond register with 100; no clearing pass is needed.
module tick_timer_delay_and_ms (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttdm_pkg::PADDR_W-1:0]    paddr,
    input  logic [ttdm_pkg::PDATA_W-1:0]    pwdata,
    output logic [ttdm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [ttdm_pkg::WORD_W-1:0]     delay_usec,
    input  logic [ttdm_pkg::WORD_W-1:0]     base_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ttdm_pkg::WORD_W-1:0]     elapsed_ms,
    output logic                            delay_done,
    output logic                            delay_overflow
);

    logic [ttdm_pkg::RATE_W-1:0]  rate_reg;
    logic [ttdm_pkg::RATE_W-1:0]  rate_next;
    logic                         reg_sel;
    ttdm_pkg::cmd_t               cmd;

    // register word decode
    assign reg_sel = (paddr[2] == ttdm_pkg::REG_TPU);
    assign pready  = 1'b1;
    assign prdata  = reg_sel
                   ? {{(ttdm_pkg::PDATA_W-ttdm_pkg::RATE_W){1'b0}}, rate_reg} : '0;

    // rate register write
    always_comb
    begin
        rate_next = rate_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            rate_next = pwdata[ttdm_pkg::RATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= ttdm_pkg::RATE_RESET;
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    // controller
    ttdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath
    ttdm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rate           (rate_reg),
        .req_type       (req_type),
        .delay_usec     (delay_usec),
        .base_ms        (base_ms),
        .elapsed_ms     (elapsed_ms),
        .delay_done     (delay_done),
        .delay_overflow (delay_overflow)
    );

endmodule

// ===== tb/tb_tick_timer_delay_and_ms.sv =====
// self-checking bench for tick_timer_delay_and_ms: queue-fed driver, checking monitor
// and an in-bench timer predictor; depends on ttdm_pkg and the block itself
`timescale 1ns / 100ps

module tb_tick_timer_delay_and_ms;

    // one request word and one result word
    typedef struct packed {
        ttdm_pkg::req_t              kind;
        logic [ttdm_pkg::WORD_W-1:0] usec;
        logic [ttdm_pkg::WORD_W-1:0] base;
    } timer_req_t;

    typedef struct packed {
        logic [ttdm_pkg::WORD_W-1:0] elapsed;
        logic                        done;
        logic                        ovf;
    } timer_res_t;

    localparam logic [ttdm_pkg::PADDR_W-1:0] TPU_ADDR =
        ttdm_pkg::PADDR_W'(4 * int'(ttdm_pkg::REG_TPU));
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int CALM_LO      = 3000;
    localparam int CALM_HI      = 9000;
    localparam int PHASE_WORDS  = 290;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ttdm_pkg::PADDR_W-1:0]  paddr = '0;
    logic [ttdm_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [ttdm_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [1:0]                    req_type = ttdm_pkg::REQ_NOP;
    logic [ttdm_pkg::WORD_W-1:0]   delay_usec = '0;
    logic [ttdm_pkg::WORD_W-1:0]   base_ms = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [ttdm_pkg::WORD_W-1:0]   elapsed_ms;
    logic                          delay_done;
    logic                          delay_overflow;

    // predictor state
    logic [ttdm_pkg::RATE_W-1:0]   model_rate = ttdm_pkg::RATE_RESET;
    logic [ttdm_pkg::CNT_W-1:0]    model_cnt = '0;
    logic [ttdm_pkg::CNT_W-1:0]    model_dl = '0;

    timer_req_t          req_backlog [$];
    timer_res_t          due_results [$];
    timer_req_t          word_now;
    timer_res_t          want_res;
    int                  err_count = 0;
    int                  results_seen = 0;
    int                  hold_left = 0;
    logic                hold_done = 1'b0;
    int                  quiet = 0;
    int                  cyc = 0;
    logic                calm;

    tick_timer_delay_and_ms dut (.*);

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    assign calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // timer behaviour: advances the copy of the state, returns the result word
    function automatic timer_res_t timer_predict(input timer_req_t r);
        timer_res_t                  res;
        logic [ttdm_pkg::WORD_W-1:0] rate;
        logic [ttdm_pkg::WORD_W-1:0] ticks;
        logic [ttdm_pkg::CNT_W-1:0]  unit;
        res  = '0;
        // a zero rate counts as one tick per microsecond
        rate = (model_rate == '0) ? ttdm_pkg::WORD_W'(1) : ttdm_pkg::WORD_W'(model_rate);
        case (r.kind)
            ttdm_pkg::REQ_TICK:
                model_cnt = model_cnt + ttdm_pkg::CNT_W'(1);
            ttdm_pkg::REQ_DELAY:
            begin
                if (r.usec > ttdm_pkg::SAT_TICKS / rate)
                begin
                    ticks   = ttdm_pkg::SAT_TICKS;
                    res.ovf = 1'b1;
                end
                else
                    ticks = r.usec * rate;
                model_dl = model_cnt + ttdm_pkg::CNT_W'(ticks);
            end
            ttdm_pkg::REQ_READ:
            begin
                unit        = ttdm_pkg::CNT_W'(rate) * ttdm_pkg::CNT_W'(ttdm_pkg::MS_PER_US);
                res.elapsed = ttdm_pkg::WORD_W'(model_cnt / unit) - r.base;
            end
            default:
                ;
        endcase
        res.done = (model_cnt >= model_dl);
        return res;
    endfunction

    task automatic flag_mismatch(input string what,
                                 input logic [ttdm_pkg::WORD_W-1:0] got,
                                 input logic [ttdm_pkg::WORD_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic queue_req(input ttdm_pkg::req_t kind,
                             input logic [ttdm_pkg::WORD_W-1:0] usec,
                             input logic [ttdm_pkg::WORD_W-1:0] base);
        timer_req_t r;
        r.kind = kind;
        r.usec = usec;
        r.base = base;
        req_backlog.push_back(r);
    endtask

    // random request mix, ticks dominate so deadlines get reached
    function automatic timer_req_t make_request();
        timer_req_t                  r;
        int                          pick;
        int                          sel;
        logic [ttdm_pkg::WORD_W-1:0] eff;
        logic [ttdm_pkg::WORD_W-1:0] lim;
        r.usec = $urandom();
        r.base = $urandom();
        eff    = (model_rate == '0) ? ttdm_pkg::WORD_W'(1) : ttdm_pkg::WORD_W'(model_rate);
        pick   = $urandom_range(0, 99);
        if (pick < 66)
            r.kind = ttdm_pkg::REQ_TICK;
        else if (pick < 80)
        begin
            r.kind = ttdm_pkg::REQ_DELAY;
            sel    = $urandom_range(0, 9);
            lim    = ttdm_pkg::SAT_TICKS / eff;
            if (sel < 5)
                r.usec = $urandom_range(0, 40);
            else if (sel < 7)
                r.usec = lim + $urandom_range(0, 2) - 1;
        end
        else if (pick < 96)
        begin
            r.kind = ttdm_pkg::REQ_READ;
            sel    = $urandom_range(0, 9);
            if (sel < 2)
                r.base = '0;
            else if (sel < 4)
                r.base = '1;
            else if (sel < 6)
                r.base = $urandom_range(0, 3);
        end
        else
            r.kind = ttdm_pkg::REQ_NOP;
        return r;
    endfunction

    // rate register write over the configuration port, upper bits random
    task automatic write_rate(input logic [ttdm_pkg::RATE_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TPU_ADDR;
        pwdata  <= {(ttdm_pkg::PDATA_W - ttdm_pkg::RATE_W)'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_rate = val;
    endtask

    // wait until every word is sent and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // driver: offers the next word, records a prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            req_type   <= ttdm_pkg::REQ_NOP;
            delay_usec <= '0;
            base_ms    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                due_results.push_back(timer_predict(word_now));
            if (!in_valid || in_ready)
            begin
                if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 10))
                begin
                    word_now = req_backlog.pop_front();
                    in_valid   <= 1'b1;
                    req_type   <= word_now.kind;
                    delay_usec <= word_now.usec;
                    base_ms    <= word_now.base;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result word, drives ready with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                    flag_mismatch("result with nothing expected", elapsed_ms, '0);
                else
                begin
                    want_res = due_results.pop_front();
                    if (elapsed_ms !== want_res.elapsed)
                        flag_mismatch("elapsed_ms", elapsed_ms, want_res.elapsed);
                    if (delay_done !== want_res.done)
                        flag_mismatch("delay_done", ttdm_pkg::WORD_W'(delay_done),
                                      ttdm_pkg::WORD_W'(want_res.done));
                    if (delay_overflow !== want_res.ovf)
                        flag_mismatch("delay_overflow", ttdm_pkg::WORD_W'(delay_overflow),
                                      ttdm_pkg::WORD_W'(want_res.ovf));
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // stimulus sequence
    initial
    begin
        int unsigned rate_plan [6];
        rate_plan[0] = 1000;
        rate_plan[1] = 1023;
        rate_plan[2] = $urandom_range(3, 1022);
        rate_plan[3] = 2;
        rate_plan[4] = 0;
        rate_plan[5] = 1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words at the reset rate
        queue_req(ttdm_pkg::REQ_NOP, '1, '1);
        queue_req(ttdm_pkg::REQ_TICK, '1, '1);
        queue_req(ttdm_pkg::REQ_READ, '1, '0);
        queue_req(ttdm_pkg::REQ_READ, '0, '1);
        queue_req(ttdm_pkg::REQ_READ, '0, ttdm_pkg::WORD_W'(1));
        queue_req(ttdm_pkg::REQ_DELAY, '0, '1);
        queue_req(ttdm_pkg::REQ_DELAY, '1, '0);
        queue_req(ttdm_pkg::REQ_NOP, '0, '0);
        // saturation boundary just below and just above
        queue_req(ttdm_pkg::REQ_DELAY,
                  ttdm_pkg::SAT_TICKS / ttdm_pkg::WORD_W'(ttdm_pkg::RATE_RESET), '0);
        queue_req(ttdm_pkg::REQ_DELAY,
                  ttdm_pkg::SAT_TICKS / ttdm_pkg::WORD_W'(ttdm_pkg::RATE_RESET) + 1, '0);
        queue_req(ttdm_pkg::REQ_DELAY, ttdm_pkg::WORD_W'(1), '1);
        repeat (4) queue_req(ttdm_pkg::REQ_TICK, '0, '0);
        queue_req(ttdm_pkg::REQ_READ, '0, 32'h5a5a_5a5a);
        queue_req(ttdm_pkg::REQ_DELAY, '0, '0);
        queue_req(ttdm_pkg::REQ_TICK, '0, '0);
        wait_drained();

        // random phases, one rate setting each
        foreach (rate_plan[p])
        begin
            write_rate(ttdm_pkg::RATE_W'(rate_plan[p]));
            @(negedge clk);
            // a short deadline chase opens each phase
            queue_req(ttdm_pkg::REQ_DELAY, ttdm_pkg::WORD_W'($urandom_range(0, 5)), '0);
            repeat (8) queue_req(ttdm_pkg::REQ_TICK, $urandom(), $urandom());
            repeat (PHASE_WORDS) req_backlog.push_back(make_request());
            wait_drained();
        end

        repeat (80) @(posedge clk);
        @(negedge clk);
        if (due_results.size() != 0)
            flag_mismatch("results never arrived",
                          ttdm_pkg::WORD_W'(due_results.size()), '0);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
